@@ sv/ccpd_pkg.sv @@
// Shared types, constants and the CRC byte step for the CAN packet deframer.
package ccpd_pkg;

  localparam logic [7:0]  SYNC0      = 8'hFF;
  localparam logic [7:0]  SYNC1      = 8'h55;
  localparam logic [7:0]  SYNC2      = 8'hAA;
  localparam int          HEAD_BYTES = 9;
  localparam int          ID_BLOCK   = 4;
  localparam int          MIN_BUFFER = 15;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [16:0] POS_MAX    = 17'h1FFFF;
  localparam logic [15:0] CMD_RESET  = 16'h0005;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_SYNC  = 3'd2;
  localparam logic [2:0] ST_BAD_CMD   = 3'd3;
  localparam logic [2:0] ST_LEN_SMALL = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_BAD_CRC   = 3'd6;

  // One classified byte, passed from the front to the back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
    logic       crc_en;
    logic       rcrc_en;
    logic       data_en;
    logic [2:0] data_idx;
    logic       cmd_en;
    logic       id_en;
    logic       short_buf;
    logic       hdr_bad;
    logic       len_small;
    logic       trunc;
    logic [3:0] plen;
  } ccpd_rec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] frame_id;
    logic [3:0]  payload_length;
    logic [63:0] payload;
  } ccpd_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ sv/ccpd_queue.sv @@
// Small first-in first-out queue of fixed-width records.
module ccpd_queue import ccpd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_rd) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (do_wr && !do_rd)      count_r <= count_r + CW'(1);
      else if (do_rd && !do_wr) count_r <= count_r - CW'(1);
    end
  end
endmodule

@@ sv/ccpd_front.sv @@
// Front: tracks byte position and length, classifies each byte for the back.
module ccpd_front import ccpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] rx_byte,
  input  logic      end_of_buffer,
  output ccpd_rec_t rec
);
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;

  logic [16:0] pkt, pkt_fin, data_off;
  logic [17:0] end_pos;
  logic [15:0] diff;
  logic        sync_bad;

  always_comb begin
    pkt      = 17'(HEAD_BYTES) + {1'b0, len_r};
    data_off = pos_r - 17'(HEAD_BYTES + ID_BLOCK);

    sync_bad = ((pos_r == 17'd0) && (rx_byte != SYNC0)) ||
               ((pos_r == 17'd1) && (rx_byte != SYNC1)) ||
               ((pos_r == 17'd2) && (rx_byte != SYNC2));
    hdr_ok_nxt = hdr_ok_r && !sync_bad;

    len_nxt = len_r;
    if (pos_r == 17'd7 || pos_r == 17'd8) len_nxt = {len_r[7:0], rx_byte};
    pkt_fin = 17'(HEAD_BYTES) + {1'b0, len_nxt};
    end_pos = {1'b0, pos_r} + 18'd1;
    diff    = len_nxt - 16'(ID_BLOCK);

    rec.rx_byte   = rx_byte;
    rec.last      = end_of_buffer;
    rec.crc_en    = (pos_r < 17'(HEAD_BYTES)) || (pos_r < pkt);
    rec.rcrc_en   = !rec.crc_en && ((pos_r == pkt) || (pos_r == pkt + 17'd1));
    rec.data_en   = rec.crc_en && (pos_r >= 17'(HEAD_BYTES + ID_BLOCK)) &&
                    (data_off < 17'(MAX_PAYLOAD));
    rec.data_idx  = data_off[2:0];
    rec.cmd_en    = (pos_r == 17'd3) || (pos_r == 17'd4);
    rec.id_en     = (pos_r == 17'd11) || (pos_r == 17'd12);
    rec.short_buf = end_pos < 18'(MIN_BUFFER);
    rec.hdr_bad   = !hdr_ok_nxt;
    rec.len_small = len_nxt < 16'(ID_BLOCK);
    rec.trunc     = ({1'b0, pkt_fin} + 18'd2) > end_pos;
    rec.plen      = (diff > 16'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD) : diff[3:0];

    pos_nxt = (pos_r < POS_MAX) ? pos_r + 17'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      hdr_ok_r <= 1'b1;
    end else if (accept) begin
      if (end_of_buffer) begin
        // start a fresh buffer
        pos_r    <= '0;
        len_r    <= '0;
        hdr_ok_r <= 1'b1;
      end else begin
        pos_r    <= pos_nxt;
        len_r    <= len_nxt;
        hdr_ok_r <= hdr_ok_nxt;
      end
    end
  end
endmodule

@@ sv/ccpd_back.sv @@
// Back: runs the CRC, captures fields and data, forms the result on the last byte.
module ccpd_back import ccpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  ccpd_rec_t   rec,
  input  logic [15:0] expected_command,
  output ccpd_res_t   res
);
  logic [15:0] crc_r, cmd_r, id_r, rcrc_r;
  logic [15:0] crc_nxt, cmd_nxt, id_nxt, rcrc_nxt;
  logic [7:0]  data_r   [MAX_PAYLOAD];
  logic [7:0]  data_nxt [MAX_PAYLOAD];
  logic [2:0]  status;
  logic [63:0] payload;

  always_comb begin
    crc_nxt  = rec.crc_en  ? crc_byte(crc_r, rec.rx_byte) : crc_r;
    cmd_nxt  = rec.cmd_en  ? {cmd_r[7:0], rec.rx_byte}   : cmd_r;
    id_nxt   = rec.id_en   ? {id_r[7:0], rec.rx_byte}    : id_r;
    rcrc_nxt = rec.rcrc_en ? {rcrc_r[7:0], rec.rx_byte}  : rcrc_r;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      data_nxt[i] = (rec.data_en && rec.data_idx == 3'(i)) ? rec.rx_byte : data_r[i];
    end

    if (rec.short_buf)                   status = ST_SHORT;
    else if (rec.hdr_bad)                status = ST_BAD_SYNC;
    else if (cmd_nxt != expected_command) status = ST_BAD_CMD;
    else if (rec.len_small)              status = ST_LEN_SMALL;
    else if (rec.trunc)                  status = ST_TRUNC;
    else if (crc_nxt != rcrc_nxt)        status = ST_BAD_CRC;
    else                                 status = ST_OK;

    payload = '0;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      if (4'(i) < rec.plen) payload[8*i +: 8] = data_nxt[i];
    end

    res.status         = status;
    res.frame_id       = (status == ST_OK) ? id_nxt   : '0;
    res.payload_length = (status == ST_OK) ? rec.plen : '0;
    res.payload        = (status == ST_OK) ? payload  : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      cmd_r  <= '0;
      id_r   <= '0;
      rcrc_r <= '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) data_r[i] <= '0;
    end else if (step) begin
      if (rec.last) begin
        // clear buffer state once the result is formed
        crc_r  <= '0;
        cmd_r  <= '0;
        id_r   <= '0;
        rcrc_r <= '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) data_r[i] <= '0;
      end else begin
        crc_r  <= crc_nxt;
        cmd_r  <= cmd_nxt;
        id_r   <= id_nxt;
        rcrc_r <= rcrc_nxt;
        for (int i = 0; i < MAX_PAYLOAD; i++) data_r[i] <= data_nxt[i];
      end
    end
  end
endmodule

@@ sv/crc_checked_can_packet_deframer_top.sv @@
// Byte-wide framed packet deframer: sync, command, length and CRC-16 check, CAN frame out.
// Throughput: one byte per cycle; a byte is taken every cycle while the byte queue has room.
// Path: a last byte's result is registered first in the front-to-back queue, then in the result queue,
// and it may wait in the first while the result queue is full; the result queue shows its head at once.
// Reset (synchronous, active low) empties both queues, clears the buffer state and sets
// the expected command word to 5.
module crc_checked_can_packet_deframer_top import ccpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_buffer,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_frame_id,
  output logic [3:0]  out_payload_length,
  output logic [63:0] out_payload,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_expected_command
);
  localparam int REC_W = $bits(ccpd_rec_t);
  localparam int RES_W = $bits(ccpd_res_t);

  logic        in_accept, mid_empty, out_full, back_step;
  logic [15:0] exp_cmd_r;
  ccpd_rec_t   front_rec, mid_rec;
  ccpd_res_t   back_res, out_res;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n)                      exp_cmd_r <= CMD_RESET;
    else if (cfg_valid && cfg_ready) exp_cmd_r <= cfg_expected_command;
  end

  ccpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .rx_byte       (in_rx_byte),
    .end_of_buffer (in_end_of_buffer),
    .rec           (front_rec)
  );

  ccpd_queue #(.WIDTH(REC_W), .DEPTH(4)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_rec),
    .rd_en   (back_step),
    .rd_data (mid_rec),
    .full    (full),
    .empty   (mid_empty)
  );

  // hold a last byte back while the result queue is full
  assign back_step = !mid_empty && (!mid_rec.last || !out_full);

  ccpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (back_step),
    .rec              (mid_rec),
    .expected_command (exp_cmd_r),
    .res              (back_res)
  );

  ccpd_queue #(.WIDTH(RES_W), .DEPTH(2)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_step && mid_rec.last),
    .wr_data (back_res),
    .rd_en   (pop),
    .rd_data (out_res),
    .full    (out_full),
    .empty   (empty)
  );

  assign out_status         = out_res.status;
  assign out_frame_id       = out_res.frame_id;
  assign out_payload_length = out_res.payload_length;
  assign out_payload        = out_res.payload;
endmodule
